// ===== src/sti_pkg.sv =====
// constants and elaboration-time helpers for the sine table interpolator
package sti_pkg;

   localparam int TABLE_SIZE_DEF  = 2048;
   localparam int PHASE_BITS_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CSR_W           = 8;

   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint ONE_Q30 = 64'sd1 <<< 30;

   // extra shift of the reciprocal constants, 2^DIV_PAD covers every divisor used
   localparam int DIV_PAD = 6;

   localparam logic MODE_LINEAR   = 1'b0;
   localparam logic MODE_ADDITION = 1'b1;

   function automatic longint mulq(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // one rom entry: odd series of sine on the first quarter, mirrored for the second
   function automatic longint sine_entry(input int idx, input int table_size,
                                         input int idx_bits, input longint amp);
      longint j;
      longint x;
      longint x2;
      longint t;
      j  = (2 * idx > table_size) ? longint'(table_size - idx) : longint'(idx);
      x  = (PI_Q30 * j) >>> idx_bits;
      x2 = mulq(x, x);
      t  = ONE_Q30;
      t  = ONE_Q30 - mulq(x2, t) / 210;
      t  = ONE_Q30 - mulq(x2, t) / 156;
      t  = ONE_Q30 - mulq(x2, t) / 110;
      t  = ONE_Q30 - mulq(x2, t) / 72;
      t  = ONE_Q30 - mulq(x2, t) / 42;
      t  = ONE_Q30 - mulq(x2, t) / 20;
      t  = ONE_Q30 - mulq(x2, t) / 6;
      t  = mulq(x, t);
      t  = (t * amp + (64'sd1 <<< 29)) >>> 30;
      if (t < 0) t = 0;
      if (t > amp) t = amp;
      return t;
   endfunction

endpackage

// ===== src/sine_table_interpolator.sv =====
// sine table interpolator: half-period rom with linear or addition-theorem interpolation
//
//   channel   direction   payload                          accepted when
//   req_*     in          phase                            req_tvalid && req_tready
//   rsp_*     out         sample                           rsp_tvalid && rsp_tready
//   csr_*     in          interp_mode                      csr_tvalid && csr_tready
//
// one request per cycle sustained while rsp_tready is high; the depth of the pipeline is
// set by the chain of series multiplies, one multiply level per stage
// the rom is a preloaded array with two registered read ports, read once per request
// reset is one cycle; the rom is preloaded, so no fill pass follows reset
// each stage stalls only when the stage after it is full, so requests keep flowing
// into empty stages while a result waits on rsp_tready
module sine_table_interpolator
   import sti_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEF,  // power of two
   parameter int PHASE_BITS  = PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((PHASE_BITS + 7) / 8) * 8 - 1:0] req_tdata,   // phase
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,  // sample
   input  logic                                    csr_tvalid,
   output logic                                    csr_tready,
   input  logic [CSR_W-1:0]                        csr_tdata    // interp_mode
);

   localparam int RSP_W    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int IDX_BITS = $clog2(TABLE_SIZE);
   localparam int FW       = PHASE_BITS - 1;
   localparam int SB       = SAMPLE_BITS;
   localparam int RW       = SAMPLE_BITS - 1;
   localparam int V_BITS   = SB + 2;
   localparam int LW       = SB + 18;
   localparam int ANG_BITS = 32 - IDX_BITS;
   localparam int A2_BITS  = 2 * ANG_BITS - 30;
   localparam int MAG_BITS = A2_BITS + 4;
   localparam int DSH      = A2_BITS + DIV_PAD;
   localparam int PAW      = SB + 32;
   localparam int PCW      = SB + ANG_BITS + 1;
   localparam int SW       = SB + 33;
   localparam int NSTG     = 10;

   localparam longint AMP_L = (64'sd1 <<< RW) - 1;
   localparam logic signed [V_BITS-1:0] AMP_V  = V_BITS'(AMP_L);
   localparam logic signed [LW-1:0]     HALF16 = LW'(64'sd32768);
   localparam logic signed [SW-1:0]     HALF30 = SW'(64'sd1 <<< 29);
   localparam logic [30:0]              ONE    = 31'(ONE_Q30);
   localparam logic [31:0]              PI_W   = 32'(PI_Q30);

   localparam logic [MAG_BITS-1:0] M42 = MAG_BITS'(((64'sd1 <<< DSH) + 41) / 42);
   localparam logic [MAG_BITS-1:0] M30 = MAG_BITS'(((64'sd1 <<< DSH) + 29) / 30);
   localparam logic [MAG_BITS-1:0] M20 = MAG_BITS'(((64'sd1 <<< DSH) + 19) / 20);
   localparam logic [MAG_BITS-1:0] M12 = MAG_BITS'(((64'sd1 <<< DSH) + 11) / 12);
   localparam logic [MAG_BITS-1:0] M6  = MAG_BITS'(((64'sd1 <<< DSH) + 5) / 6);

   // exact quotient by a constant through its scaled reciprocal
   function automatic logic [A2_BITS-1:0] cdiv(input logic [A2_BITS-1:0] x,
                                                input logic [MAG_BITS-1:0] m);
      logic [A2_BITS+MAG_BITS-1:0] p;
      p = x * m;
      return A2_BITS'(p >> DSH);
   endfunction

   function automatic logic [A2_BITS-1:0] mul_a2(input logic [A2_BITS-1:0] x,
                                                  input logic [30:0] y);
      logic [A2_BITS+30:0] p;
      p = x * y;
      return p[A2_BITS+29:30];
   endfunction

   // half-period table
   logic [RW-1:0]    rom_mem [TABLE_SIZE];

   // control
   logic             mode_ff;
   logic [NSTG:1]    vld_ff;
   logic [NSTG:1]    load;
   logic             linear;

   // stage 1
   logic [FW-1:0]          low_in;
   logic [FW+IDX_BITS-1:0] pos_in;
   logic [IDX_BITS-1:0]    idx_in;
   logic [IDX_BITS-1:0]    addr_b_in;
   logic [FW+15:0]         fext_in;
   logic [15:0]            f_in;
   logic [47:0]            angp_in;
   logic [15:0]            f_ff;
   logic [RW-1:0]          rom_a_ff;
   logic [RW-1:0]          rom_b_ff;
   logic                   bzero_ff;
   logic                   bneg_ff;

   // carried fields
   logic                       upper_ff [1:9];
   logic [ANG_BITS-1:0]        ang_ff   [1:7];
   logic [A2_BITS-1:0]         a2_ff    [2:5];
   logic signed [SB-1:0]       a_ff     [2:8];
   logic signed [SB-1:0]       c_ff     [2:8];
   logic signed [V_BITS-1:0]   v0_ff    [3:9];
   logic [30:0]                cosb_ff  [7:8];

   // stage 2
   logic signed [SB-1:0]       a_in;
   logic signed [SB-1:0]       bval_in;
   logic signed [SB-1:0]       c_in;
   logic signed [SB:0]         diff_in;
   logic signed [LW-1:0]       lin_in;
   logic [2*ANG_BITS-1:0]      sq_in;
   logic signed [LW-1:0]       lin_ff;

   // stage 3
   logic signed [LW-1:0]       lsum_in;
   logic signed [LW-1:0]       lrnd_in;
   logic [A2_BITS-1:0]         q42_ff;
   logic [A2_BITS-1:0]         q30_ff;

   // stages 4 to 8
   logic [A2_BITS-1:0]         p42_ff;
   logic [A2_BITS-1:0]         p30_ff;
   logic [A2_BITS-1:0]         q20_ff;
   logic [A2_BITS-1:0]         q12_ff;
   logic [A2_BITS-1:0]         p20_ff;
   logic [A2_BITS-1:0]         p12_ff;
   logic [A2_BITS-1:0]         q6_ff;
   logic [ANG_BITS+30:0]       sinp_in;
   logic [ANG_BITS-1:0]        sinb_ff;

   // stage 9 and 10
   logic signed [PAW-1:0]      pa_in;
   logic signed [PCW-1:0]      pc_in;
   logic signed [PAW-1:0]      pa_ff;
   logic signed [PCW-1:0]      pc_ff;
   logic signed [SW-1:0]       ssum_in;
   logic signed [V_BITS-1:0]   v1_in;
   logic signed [V_BITS-1:0]   vpick_in;
   logic signed [V_BITS-1:0]   vsat_in;
   logic signed [V_BITS-1:0]   vneg_in;
   logic signed [SB-1:0]       sample_in;
   logic signed [SB-1:0]       sample_ff;

   // preloaded half-period table, first quarter by odd series, second mirrored
   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         rom_mem[i] = RW'(sine_entry(i, TABLE_SIZE, IDX_BITS, AMP_L));
      end
   end

   assign linear = (mode_ff == MODE_LINEAR);

   // configuration
   assign csr_tready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
      end else if (csr_tvalid) begin
         mode_ff <= csr_tdata[0];
      end
   end

   // stage advance: a stage loads when it is empty or the next one loads
   always_comb begin
      load[NSTG] = !vld_ff[NSTG] || rsp_tready;
      for (int k = NSTG - 1; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
   end

   assign req_tready = load[1];
   assign rsp_tvalid = vld_ff[NSTG];
   assign rsp_tdata  = RSP_W'($unsigned(sample_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[1]) vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= NSTG; k++) begin
            if (load[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: split phase, read rom at both addresses, start the angle
   assign low_in    = req_tdata[FW-1:0];
   assign pos_in    = {low_in, {IDX_BITS{1'b0}}};
   assign idx_in    = pos_in[FW+IDX_BITS-1 -: IDX_BITS];
   assign fext_in   = {pos_in[FW-1:0], 16'b0};
   assign f_in      = fext_in[FW+15 -: 16];
   assign angp_in   = f_in * PI_W;
   assign addr_b_in = linear ? idx_in + IDX_BITS'(1)
                             : {~idx_in[IDX_BITS-1], idx_in[IDX_BITS-2:0]};

   always_ff @(posedge clock) begin
      if (load[1]) begin
         rom_a_ff    <= rom_mem[idx_in];
         rom_b_ff    <= rom_mem[addr_b_in];
         f_ff        <= f_in;
         bzero_ff    <= linear && (idx_in == {IDX_BITS{1'b1}});
         bneg_ff     <= !linear && idx_in[IDX_BITS-1];
      end
   end

   // stage 2: signed rom values, linear product, angle squared
   assign a_in    = $signed({1'b0, rom_a_ff});
   assign bval_in = $signed({1'b0, rom_b_ff});
   assign c_in    = bzero_ff ? '0 : (bneg_ff ? -bval_in : bval_in);
   assign diff_in = (SB + 1)'(c_in) - (SB + 1)'(a_in);
   assign lin_in  = diff_in * $signed({1'b0, f_ff});
   assign sq_in   = ang_ff[1] * ang_ff[1];

   always_ff @(posedge clock) begin
      if (load[2]) begin
         lin_ff   <= lin_in;
      end
   end

   // stage 3: linear result, first quotients
   assign lsum_in = lin_ff + HALF16;
   assign lrnd_in = lsum_in >>> 16;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         q42_ff   <= cdiv(a2_ff[2], M42);
         q30_ff   <= cdiv(a2_ff[2], M30);
      end
   end

   // stages 4 to 8: nested series for sin b and cos b
   always_ff @(posedge clock) begin
      if (load[4]) begin
         p42_ff <= mul_a2(a2_ff[3], ONE - 31'(q42_ff));
         p30_ff <= mul_a2(a2_ff[3], ONE - 31'(q30_ff));
      end
      if (load[5]) begin
         q20_ff <= cdiv(p42_ff, M20);
         q12_ff <= cdiv(p30_ff, M12);
      end
      if (load[6]) begin
         p20_ff <= mul_a2(a2_ff[5], ONE - 31'(q20_ff));
         p12_ff <= mul_a2(a2_ff[5], ONE - 31'(q12_ff));
      end
      if (load[7]) begin
         q6_ff      <= cdiv(p20_ff, M6);
         cosb_ff[7] <= ONE - 31'(p12_ff >> 1);
      end
      if (load[8]) begin
         sinb_ff    <= sinp_in[ANG_BITS+29:30];
         cosb_ff[8] <= cosb_ff[7];
      end
   end

   assign sinp_in = ang_ff[7] * (ONE - 31'(q6_ff));

   // carried fields
   always_ff @(posedge clock) begin
      if (load[1]) begin
         upper_ff[1] <= req_tdata[PHASE_BITS-1];
         ang_ff[1]   <= angp_in[47 -: ANG_BITS];
      end
      if (load[2]) begin
         a_ff[2]  <= a_in;
         c_ff[2]  <= c_in;
         a2_ff[2] <= sq_in[2*ANG_BITS-1:30];
      end
      if (load[3]) begin
         v0_ff[3] <= V_BITS'(a_ff[2]) + V_BITS'(lrnd_in);
      end
      for (int k = 2; k <= 9; k++) begin
         if (load[k]) upper_ff[k] <= upper_ff[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
         if (load[k]) ang_ff[k] <= ang_ff[k-1];
      end
      for (int k = 3; k <= 5; k++) begin
         if (load[k]) a2_ff[k] <= a2_ff[k-1];
      end
      for (int k = 3; k <= 8; k++) begin
         if (load[k]) begin
            a_ff[k] <= a_ff[k-1];
            c_ff[k] <= c_ff[k-1];
         end
      end
      for (int k = 4; k <= 9; k++) begin
         if (load[k]) v0_ff[k] <= v0_ff[k-1];
      end
   end

   // stage 9: addition theorem products
   assign pa_in = a_ff[8] * $signed({1'b0, cosb_ff[8]});
   assign pc_in = c_ff[8] * $signed({1'b0, sinb_ff});

   always_ff @(posedge clock) begin
      if (load[9]) begin
         pa_ff <= pa_in;
         pc_ff <= pc_in;
      end
   end

   // stage 10: round, select, saturate, fold into the upper half
   assign ssum_in = SW'(pa_ff) + SW'(pc_ff) + HALF30;
   assign v1_in   = V_BITS'(ssum_in >>> 30);

   always_comb begin
      vpick_in = linear ? v0_ff[9] : v1_in;
      if (vpick_in > AMP_V) begin
         vsat_in = AMP_V;
      end else if (vpick_in < -AMP_V) begin
         vsat_in = -AMP_V;
      end else begin
         vsat_in = vpick_in;
      end
      vneg_in   = upper_ff[9] ? -vsat_in : vsat_in;
      sample_in = SB'(vneg_in);
   end

   always_ff @(posedge clock) begin
      if (load[10]) begin
         sample_ff <= sample_in;
      end
   end

   // checks
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted request did not enter the first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_drain_opens: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> req_tready)
      else $error("input blocked while the output drains");

   a_linear_sign: assert property (@(posedge clock) disable iff (reset)
      (load[10] && vld_ff[9] && linear && !upper_ff[9]) |=> !sample_ff[SB-1])
      else $error("negative linear sample in the lower half period");

endmodule
